### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A clocked property, switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// An implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/wdbr_pkg.sv
// ----------------------------------------------------------------------------
// wdbr_pkg
// Constants, types and register codes of the debouncer and blink stepper.
// ----------------------------------------------------------------------------
package wdbr_pkg;

    localparam int WINDOW      = 1024;
    localparam int PERIOD_BITS = 20;

    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int WP_W       = $clog2(WINDOW);
    localparam int THRESH_W   = 11;
    localparam int HALF_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int CMP_W      = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;
    localparam int WIDE_W     = (PERIOD_BITS > HALF_W) ? PERIOD_BITS : HALF_W;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 2'd2;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 11'd768;
    localparam logic [HALF_W-1:0]   MAXP_RESET   = 20'd500000;
    localparam logic [HALF_W-1:0]   MINP_RESET   = 20'd7812;

    typedef logic [PERIOD_BITS-1:0] period_t;

    // What the debouncer reports for one sample.
    typedef struct packed {
        logic level;
        logic changed;
        logic halve;
    } wdbr_event_t;

endpackage

### sv/wdbr_sample_if.sv
// ----------------------------------------------------------------------------
// wdbr_sample_if
// Valid/ready channel carrying one raw button sample per beat.
// ----------------------------------------------------------------------------
interface wdbr_sample_if;
    logic valid;
    logic ready;
    logic button_sample;

    modport source (output valid, output button_sample, input ready);
    modport sink   (input valid, input button_sample, output ready);
endinterface

### sv/wdbr_result_if.sv
// ----------------------------------------------------------------------------
// wdbr_result_if
// Valid/ready channel carrying the LED and debounced button state per beat.
// ----------------------------------------------------------------------------
interface wdbr_result_if;
    logic        valid;
    logic        ready;
    logic        led_on;
    logic        button_level;
    logic        level_changed;
    logic [19:0] current_half_period;

    modport source (output valid, output led_on, output button_level,
                    output level_changed, output current_half_period, input ready);
    modport sink   (input valid, input led_on, input button_level,
                    input level_changed, input current_half_period, output ready);
endinterface

### sv/wdbr_front.sv
// ----------------------------------------------------------------------------
// wdbr_front
// Sliding-window majority debouncer: takes samples and classifies each one.
// ----------------------------------------------------------------------------
module wdbr_front
    import wdbr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    wdbr_sample_if.sink           samples,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output wdbr_event_t           evt,
    output logic                  evt_push,
    input  logic                  evt_full
);

    logic                win_mem [WINDOW];
    logic                rd_data_reg;

    logic [THRESH_W-1:0] threshold_reg;
    logic [WP_W-1:0]     wp_reg,     wp_next;
    logic [CNT_W-1:0]    ones_reg,   ones_next;
    logic [CNT_W-1:0]    since_reg,  since_next;
    logic                level_reg,  level_next;
    logic                press_reg,  press_next;

    logic                accept;
    logic                old_sample;
    logic [CNT_W-1:0]    ones_upd;
    logic                rise;
    logic                fall;
    logic                changed;
    logic [WP_W:0]       wp_inc;
    logic [WP_W-1:0]     rd_addr;

    assign samples.ready = !evt_full;
    assign accept        = samples.valid && samples.ready;
    assign evt_push      = accept;

    // Since the last refill every entry equals the debounced level, until the
    // write pointer has gone once round the ring; only then is the memory valid.
    always_comb
    begin
        old_sample = (since_reg == CNT_W'(WINDOW)) ? rd_data_reg : level_reg;
        ones_upd   = ones_reg - CNT_W'(old_sample) + CNT_W'(samples.button_sample);
        rise       = !level_reg && (CMP_W'(ones_upd) >= CMP_W'(threshold_reg));
        fall       = level_reg && (CMP_W'(ones_upd) <= CMP_W'(threshold_reg));
        changed    = rise || fall;
        level_next = level_reg ^ changed;

        wp_inc  = {1'b0, wp_reg} + (WP_W + 1)'(1);
        wp_next = (wp_inc >= (WP_W + 1)'(WINDOW)) ? '0 : wp_inc[WP_W-1:0];
        rd_addr = accept ? wp_next : wp_reg;

        if (changed)
        begin
            ones_next  = level_next ? CNT_W'(WINDOW) : '0;
            since_next = '0;
        end
        else
        begin
            ones_next  = ones_upd;
            since_next = (since_reg == CNT_W'(WINDOW)) ? since_reg
                                                       : since_reg + CNT_W'(1);
        end

        press_next = press_reg;
        if (rise)
        begin
            press_next = 1'b1;
        end
        else if (fall)
        begin
            press_next = 1'b0;
        end

        evt.level   = level_next;
        evt.changed = changed;
        evt.halve   = fall && press_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_mem[wp_reg] <= samples.button_sample;
        end
        rd_data_reg <= win_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
            wp_reg        <= '0;
            ones_reg      <= '0;
            since_reg     <= '0;
            level_reg     <= 1'b0;
            press_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_index == REG_THRESHOLD))
            begin
                threshold_reg <= cfg_data[THRESH_W-1:0];
            end
            if (accept)
            begin
                wp_reg    <= wp_next;
                ones_reg  <= ones_next;
                since_reg <= since_next;
                level_reg <= level_next;
                press_reg <= press_next;
            end
        end
    end

endmodule

### sv/wdbr_queue.sv
// ----------------------------------------------------------------------------
// wdbr_queue
// Two-entry queue of debouncer events between the front and the back.
// ----------------------------------------------------------------------------
module wdbr_queue
    import wdbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  wdbr_event_t push_data,
    output logic        full,
    input  logic        pop,
    output wdbr_event_t pop_data,
    output logic        empty
);

    wdbr_event_t entries [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### sv/wdbr_back.sv
// ----------------------------------------------------------------------------
// wdbr_back
// Blink-rate stepper: halves the period on each release and drives the LED.
// ----------------------------------------------------------------------------
module wdbr_back
    import wdbr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  wdbr_event_t           evt,
    input  logic                  evt_valid,
    output logic                  evt_pop,
    wdbr_result_if.source         results
);

    logic [HALF_W-1:0] max_period_reg;
    logic [HALF_W-1:0] min_period_reg;
    period_t           pending_reg, pending_next;
    period_t           active_reg;
    period_t           blink_reg;
    logic              led_reg;

    logic              out_valid_reg;
    logic              out_led_reg;
    logic              out_level_reg;
    logic              out_changed_reg;
    logic [HALF_W-1:0] out_period_reg;

    logic              take;
    period_t           halved;
    period_t           blink_inc;
    logic              toggle;

    assign take    = evt_valid && (!out_valid_reg || results.ready);
    assign evt_pop = take;

    always_comb
    begin
        halved = pending_reg >> 1;
        pending_next = pending_reg;
        if (evt.halve)
        begin
            pending_next = (WIDE_W'(halved) < WIDE_W'(min_period_reg))
                         ? PERIOD_BITS'(max_period_reg) : halved;
        end
        blink_inc = blink_reg + PERIOD_BITS'(1);
        toggle    = (blink_inc >= active_reg) || (blink_inc == '0);
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_led_reg     <= led_reg;
            out_level_reg   <= evt.level;
            out_changed_reg <= evt.changed;
            out_period_reg  <= HALF_W'(pending_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_period_reg <= MAXP_RESET;
            min_period_reg <= MINP_RESET;
            pending_reg    <= PERIOD_BITS'(MAXP_RESET);
            active_reg     <= PERIOD_BITS'(MAXP_RESET);
            blink_reg      <= '0;
            led_reg        <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_index == REG_MAX_PERIOD))
            begin
                max_period_reg <= cfg_data[HALF_W-1:0];
            end
            if (cfg_wr_en && (cfg_index == REG_MIN_PERIOD))
            begin
                min_period_reg <= cfg_data[HALF_W-1:0];
            end
            if (take)
            begin
                pending_reg <= pending_next;
                blink_reg   <= toggle ? '0 : blink_inc;
                led_reg     <= led_reg ^ toggle;
                // A new on-phase picks up the pending period.
                if (toggle && !led_reg)
                begin
                    active_reg <= pending_next;
                end
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid               = out_valid_reg;
    assign results.led_on              = out_led_reg;
    assign results.button_level        = out_level_reg;
    assign results.level_changed       = out_changed_reg;
    assign results.current_half_period = out_period_reg;

endmodule

### sv/window_debounce_blink_rate_stepper.sv
// ----------------------------------------------------------------------------
// window_debounce_blink_rate_stepper
// Sliding-window button debouncer that steps the blink rate of an LED.
// ----------------------------------------------------------------------------
// Usage:
// One raw button sample enters per beat on the samples channel and exactly one
// result beat leaves on the results channel for it, in order: the LED level for
// that tick, the debounced level, a change flag and the pending half-period.
// One sample per cycle is sustained while the queue has room. The debouncer
// keeps its window in a memory with one write and one read port, whose read
// for the next slot is registered ahead of use, and the running ones count
// updates in the same cycle as the sample.
// A two-entry event queue sits between the debouncer and the blinker, and the
// result is held in an output register, so a stalled receiver first fills the
// output register and then the queue; samples are refused only when the queue
// is full. No clearing pass is needed after reset: the window reads as its last
// fill level until the write pointer has been once round it.
// Reset restores the register defaults, clears the count and fill state, and
// starts the LED in its on-phase. Configuration writes are taken at any cycle.
// ----------------------------------------------------------------------------
module window_debounce_blink_rate_stepper
    import wdbr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    wdbr_sample_if.sink           samples,
    wdbr_result_if.source         results,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    wdbr_event_t push_evt;
    wdbr_event_t pop_evt;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;

    wdbr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt       (push_evt),
        .evt_push  (push),
        .evt_full  (full)
    );

    wdbr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_evt),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_evt),
        .empty     (empty)
    );

    wdbr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt       (pop_evt),
        .evt_valid (!empty),
        .evt_pop   (pop),
        .results   (results)
    );

endmodule

### sv/wdbr_checker.sv
// ----------------------------------------------------------------------------
// wdbr_checker
// Port-level checks of the debouncer and blink stepper.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wdbr_checker
    import wdbr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              led_on,
    input logic              button_level,
    input logic              level_changed,
    input logic [HALF_W-1:0] current_half_period
);

    logic              in_beat;
    logic              out_beat;
    logic [2:0]        outstanding_reg;
    logic              prev_level_reg;
    logic [HALF_W-1:0] prev_period_reg;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            prev_level_reg  <= 1'b0;
            prev_period_reg <= HALF_W'(PERIOD_BITS'(MAXP_RESET));
        end
        else
        begin
            if (in_beat && !out_beat)
            begin
                outstanding_reg <= outstanding_reg + 3'd1;
            end
            else if (out_beat && !in_beat)
            begin
                outstanding_reg <= outstanding_reg - 3'd1;
            end
            if (out_beat)
            begin
                prev_level_reg  <= button_level;
                prev_period_reg <= current_half_period;
            end
        end
    end

    `ASSERT_CLK(a_stall_holds, (out_valid && !out_ready) |=> (out_valid && $stable(led_on) && $stable(button_level) && $stable(level_changed) && $stable(current_half_period)), "result beat changed while stalled")
    `ASSERT_IMPLY(a_no_invented_beat, out_beat, outstanding_reg != 3'd0, "result beat without a sample")
    `ASSERT_IMPLY(a_change_flag, out_beat, level_changed == (button_level != prev_level_reg), "change flag disagrees with level")
    `ASSERT_IMPLY(a_period_on_release, out_beat && !(level_changed && !button_level), current_half_period == prev_period_reg, "period moved without a release")

endmodule

bind window_debounce_blink_rate_stepper wdbr_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (samples.valid),
    .in_ready            (samples.ready),
    .out_valid           (results.valid),
    .out_ready           (results.ready),
    .led_on              (results.led_on),
    .button_level        (results.button_level),
    .level_changed       (results.level_changed),
    .current_half_period (results.current_half_period)
);
